[rtl/pcc_pkg.sv]
// pcc_pkg: shared types, codes and color tables of the palette color cycler.
// Used by pcc_entry_gen and palette_color_cycler_unit; depends on nothing.
`default_nettype none

package pcc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_ENABLE = 1'b1;

  // Input operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Timing and palette constants
  localparam logic [15:0] INTERVAL_MS  = 16'd200;
  localparam logic [7:0]  FIRST_ENTRY  = 8'd229;
  localparam logic [4:0]  LAST_K       = 5'd25;
  localparam logic [5:0]  PULSE_TOP    = 6'd60;
  localparam logic [5:0]  PULSE_STEP   = 6'd4;

  // Color groups
  typedef enum logic [2:0] {
    GRP_WASTE  = 3'd0,
    GRP_GLOW   = 3'd1,
    GRP_FIRE   = 3'd2,
    GRP_BURN   = 3'd3,
    GRP_SCREEN = 3'd4,
    GRP_PULSE  = 3'd5
  } pcc_group_t;

  // Rotation start of each group
  typedef struct packed {
    logic [1:0] waste;
    logic [2:0] glow;
    logic [2:0] fire;
    logic [2:0] burn;
    logic [2:0] screen;
  } pcc_phase_t;

  // 8-bit RGB of a group slot, packed as {r, g, b}
  function automatic logic [23:0] pcc_color(input pcc_group_t g, input logic [2:0] s);
    logic [23:0] c;
    c = 24'h000000;
    case (g)
      GRP_WASTE: begin
        case (s)
          3'd0:    c = 24'h006C00;
          3'd1:    c = 24'h0B7307;
          3'd2:    c = 24'h1B7B0F;
          3'd3:    c = 24'h2B831B;
          default: c = 24'h000000;
        endcase
      end
      GRP_GLOW: begin
        case (s)
          3'd0:    c = 24'h6B6B6F;
          3'd1:    c = 24'h63677F;
          3'd2:    c = 24'h576B8F;
          3'd3:    c = 24'h0093A3;
          3'd4:    c = 24'h6BBBFF;
          default: c = 24'h000000;
        endcase
      end
      GRP_FIRE: begin
        case (s)
          3'd0:    c = 24'hFF0000;
          3'd1:    c = 24'hD70000;
          3'd2:    c = 24'h932B0B;
          3'd3:    c = 24'hFF7700;
          3'd4:    c = 24'hFF3B00;
          default: c = 24'h000000;
        endcase
      end
      GRP_BURN: begin
        case (s)
          3'd0:    c = 24'h470000;
          3'd1:    c = 24'h7B0000;
          3'd2:    c = 24'hB30000;
          3'd3:    c = 24'h7B0000;
          3'd4:    c = 24'h470000;
          default: c = 24'h000000;
        endcase
      end
      GRP_SCREEN: begin
        case (s)
          3'd0:    c = 24'h533F2B;
          3'd1:    c = 24'h4B3B2B;
          3'd2:    c = 24'h433727;
          3'd3:    c = 24'h3F3327;
          3'd4:    c = 24'h372F23;
          3'd5:    c = 24'h332B23;
          default: c = 24'h000000;
        endcase
      end
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/pcc_entry_gen.sv]
// pcc_entry_gen: color of one palette entry from its offset, the group phases
// and the pulse level. Uses pcc_pkg for the tables and the phase struct.
`default_nettype none

module pcc_entry_gen (
  input  wire logic [4:0]         k,
  input  wire pcc_pkg::pcc_phase_t phase,
  input  wire logic [5:0]         pulse_red,
  output logic [7:0]              entry_index,
  output logic [5:0]              red_level,
  output logic [5:0]              green_level,
  output logic [5:0]              blue_level,
  output logic                    last_entry
);
  import pcc_pkg::*;

  pcc_group_t  grp;
  logic [4:0]  base;
  logic [3:0]  n;
  logic [2:0]  ph;
  logic [2:0]  loc;
  logic [3:0]  sum;
  logic [2:0]  slot;
  logic [23:0] rgb;

  // Find the group of this entry
  always_comb begin
    grp  = GRP_PULSE;
    base = LAST_K;
    n    = 4'd1;
    ph   = 3'd0;
    case (k) inside
      [5'd0:5'd3]: begin
        grp = GRP_WASTE;  base = 5'd0;  n = 4'd4; ph = {1'b0, phase.waste};
      end
      [5'd4:5'd8]: begin
        grp = GRP_GLOW;   base = 5'd4;  n = 4'd5; ph = phase.glow;
      end
      [5'd9:5'd13]: begin
        grp = GRP_FIRE;   base = 5'd9;  n = 4'd5; ph = phase.fire;
      end
      [5'd14:5'd18]: begin
        grp = GRP_BURN;   base = 5'd14; n = 4'd5; ph = phase.burn;
      end
      [5'd19:5'd24]: begin
        grp = GRP_SCREEN; base = 5'd19; n = 4'd6; ph = phase.screen;
      end
      default: begin
        grp = GRP_PULSE;  base = LAST_K; n = 4'd1; ph = 3'd0;
      end
    endcase
  end

  // Rotated slot: (phase + local offset) mod group size
  assign loc  = 3'(k - base);
  assign sum  = {1'b0, ph} + {1'b0, loc};
  assign slot = (sum >= n) ? 3'(sum - n) : sum[2:0];
  assign rgb  = pcc_color(grp, slot);

  // Drop the two low bits of each component; the pulse entry is red only
  always_comb begin
    if (grp == GRP_PULSE) begin
      red_level   = pulse_red;
      green_level = 6'd0;
      blue_level  = 6'd0;
    end else begin
      red_level   = rgb[23:18];
      green_level = rgb[15:10];
      blue_level  = rgb[7:2];
    end
  end

  assign entry_index = FIRST_ENTRY + {3'b000, k};
  assign last_entry  = (k == LAST_K);

endmodule

`default_nettype wire

[rtl/palette_color_cycler_unit.sv]
// palette_color_cycler_unit: sequencer, timer check and output register.
// Depends on pcc_pkg and pcc_entry_gen.
//
// Usage: the input channel (in_valid/in_stall, in_op, in_now_ms) takes one
// transaction at a time. A restart clears the update timer and yields
// nothing. A tick is checked in the cycle after it is taken: when cycling
// is enabled and in_now_ms minus the last update time reaches 200 ms times
// speed_factor, the block steps the red pulse, sends entries 229 to 254 in
// ascending order on the output channel, one transaction per cycle while
// out_stall stays low, out_last_entry marking entry 254, and then rotates
// its color groups. The first entry is registered in the emit state after
// the check state. An updating tick holds in_stall high through the check
// state and until all 26 entries are loaded; a tick without update holds
// in_stall only through the check state. The next transaction is taken only
// when the block is back in idle: a stall on out_stall holds the current
// entry in the single output register and pauses the sequence.
// Reset (rst_n low, synchronous) clears timer, phases and pulse, sets
// speed_factor to 1 and cycling enabled, and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// belong only in idle periods.
`default_nettype none

module palette_color_cycler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration port
  input  wire logic                          cfg_we,
  input  wire logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [31:0]                   in_now_ms,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_entry_index,
  output logic [5:0]                         out_red_level,
  output logic [5:0]                         out_green_level,
  output logic [5:0]                         out_blue_level,
  output logic                               out_last_entry
);
  import pcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic        enable_r, enable_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] now_r, now_nxt;
  pcc_phase_t  phase_r, phase_nxt;
  logic [5:0]  pulse_red_r, pulse_red_nxt;
  logic        rising_r, rising_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  out_index_r;
  logic [5:0]  out_red_r, out_green_r, out_blue_r;
  logic        out_last_r;

  logic        in_take;
  logic        load_out;
  logic [31:0] elapsed;
  logic        due;
  logic        flip;

  logic [7:0]  gen_index;
  logic [5:0]  gen_red, gen_green, gen_blue;
  logic        gen_last;

  // Color of the entry under the counter
  pcc_entry_gen u_gen (
    .k           (cnt_r),
    .phase       (phase_r),
    .pulse_red   (pulse_red_r),
    .entry_index (gen_index),
    .red_level   (gen_red),
    .green_level (gen_green),
    .blue_level  (gen_blue),
    .last_entry  (gen_last)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign elapsed  = now_r - last_r;
  assign due      = enable_r && (elapsed >= {16'd0, interval_r});
  assign flip     = (pulse_red_r == 6'd0) || (pulse_red_r == PULSE_TOP);

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    interval_nxt  = interval_r;
    enable_nxt    = enable_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    phase_nxt     = phase_r;
    pulse_red_nxt = pulse_red_r;
    rising_nxt    = rising_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = load_out || (out_valid_r && out_stall);

    if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED_FACTOR: interval_nxt = 16'(cfg_wdata) * INTERVAL_MS;
        CFG_CYCLE_ENABLE: enable_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_op == OP_RESTART) begin
            last_nxt = 32'd0;
          end else begin
            now_nxt   = in_now_ms;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // Take the update: stamp the time and step the pulse
        if (due) begin
          last_nxt   = now_r;
          rising_nxt = rising_r ^ flip;
          if (rising_r ^ flip) begin
            pulse_red_nxt = pulse_red_r + PULSE_STEP;
          end else begin
            pulse_red_nxt = pulse_red_r - PULSE_STEP;
          end
          cnt_nxt   = 5'd0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          cnt_nxt = cnt_r + 5'd1;
          // Rotate every group once the last entry is out
          if (cnt_r == LAST_K) begin
            phase_nxt.waste  = phase_r.waste - 2'd1;
            phase_nxt.glow   = (phase_r.glow == 3'd0) ? 3'd4 : phase_r.glow - 3'd1;
            phase_nxt.fire   = (phase_r.fire == 3'd0) ? 3'd4 : phase_r.fire - 3'd1;
            phase_nxt.burn   = (phase_r.burn == 3'd0) ? 3'd4 : phase_r.burn - 3'd1;
            phase_nxt.screen = (phase_r.screen == 3'd0) ? 3'd5 : phase_r.screen - 3'd1;
            cnt_nxt          = 5'd0;
            state_nxt        = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      interval_r  <= INTERVAL_MS;
      enable_r    <= 1'b1;
      last_r      <= 32'd0;
      phase_r     <= '0;
      pulse_red_r <= 6'd0;
      rising_r    <= 1'b0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      interval_r  <= interval_nxt;
      enable_r    <= enable_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
      pulse_red_r <= pulse_red_nxt;
      rising_r    <= rising_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (load_out) begin
      out_index_r <= gen_index;
      out_red_r   <= gen_red;
      out_green_r <= gen_green;
      out_blue_r  <= gen_blue;
      out_last_r  <= gen_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_index_r;
  assign out_red_level   = out_red_r;
  assign out_green_level = out_green_r;
  assign out_blue_level  = out_blue_r;
  assign out_last_entry  = out_last_r;

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_RESTART) |=> (last_r == 32'd0))
    else $error("restart did not clear the update timer");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pulse_red_r[1:0] == 2'b00) && (pulse_red_r <= PULSE_TOP))
    else $error("pulse level left its range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r <= LAST_K))
    else $error("entry counter overran");

  a_last_is_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_entry) |-> (out_entry_index == 8'd254))
    else $error("last entry flag on wrong entry");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> in_stall)
    else $error("input taken during emission");
`endif

endmodule

`default_nettype wire
